>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the digest checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define XXH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define XXH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/xxh32_pkg.sv
// ----------------------------------------------------------------------------
// xxh32 package
// constants, types and helper functions of the xxhash32 digest block
// ----------------------------------------------------------------------------
package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    localparam logic [31:0] LANE0_INIT = 32'h24234428;
    localparam logic [31:0] LANE1_INIT = PRIME2;
    localparam logic [31:0] LANE2_INIT = 32'h00000000;
    localparam logic [31:0] LANE3_INIT = 32'h61C8864F;

    typedef enum logic [2:0] {
        PR_1,
        PR_2,
        PR_3,
        PR_4,
        PR_5
    } t_prime;

    typedef struct packed {
        logic        en;
        logic [31:0] operand;
        t_prime      sel;
    } t_mul_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ABS_MUL,
        S_ABS_ADD,
        S_ABS_ROT,
        S_ABS_WB,
        S_FIN_INIT,
        S_MERGE,
        S_TAIL_CHK,
        S_TAIL_MUL,
        S_TAIL_ADD,
        S_TAIL_ROT,
        S_TAIL_WB,
        S_AVAL_X15,
        S_AVAL_M2,
        S_AVAL_X13,
        S_AVAL_M3,
        S_DONE
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] prime_value(input t_prime p);
        case (p)
            PR_1:    prime_value = PRIME1;
            PR_2:    prime_value = PRIME2;
            PR_3:    prime_value = PRIME3;
            PR_4:    prime_value = PRIME4;
            PR_5:    prime_value = PRIME5;
            default: prime_value = PRIME1;
        endcase
    endfunction

    function automatic logic [4:0] lane_rot(input logic [1:0] k);
        case (k)
            2'd0:    lane_rot = 5'd1;
            2'd1:    lane_rot = 5'd7;
            2'd2:    lane_rot = 5'd12;
            default: lane_rot = 5'd18;
        endcase
    endfunction

    function automatic logic [31:0] lane_init(input logic [1:0] k);
        case (k)
            2'd0:    lane_init = LANE0_INIT;
            2'd1:    lane_init = LANE1_INIT;
            2'd2:    lane_init = LANE2_INIT;
            default: lane_init = LANE3_INIT;
        endcase
    endfunction

endpackage

>>> design/xxhash32_stream_digest.sv
// ----------------------------------------------------------------------------
// xxhash32 stream digest
// Computes the seed-0 32-bit xxHash of a byte message taken one byte per
// transfer; a transfer with the last flag ends the message and one digest
// transfer follows. A byte that completes a 16-byte stripe is absorbed in
// four lanes of four steps each through the single shared 32 x 32
// multiplier, and o_stall holds off further bytes until it is done. The end
// of a message merges the lanes once a stripe has been absorbed, then takes
// the whole tail words and the remaining tail bytes through the same
// multiplier. A finished digest waits in an output register while the next
// message is taken in.
// ----------------------------------------------------------------------------
module xxhash32_stream_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest
);
    import xxh32_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_word [4];
    logic [31:0] r_lane [4];
    logic [3:0]  r_fill;
    logic [31:0] r_len;
    logic        r_seen;
    logic        r_last;
    logic [1:0]  r_cnt;
    logic [3:0]  r_pos;
    logic        r_wmode;
    logic [31:0] r_h;
    logic        r_o_valid;
    logic [31:0] r_digest;

    t_mul_req    w_req;
    logic [31:0] w_prod;
    logic        w_in_take;
    logic        w_out_free;
    logic [1:0]  w_widx;
    logic [31:0] w_word;
    logic [31:0] w_shift;
    logic [7:0]  w_byte;
    logic [31:0] w_lane;
    logic        w_word_step;
    logic        w_byte_step;

    xxh32_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    assign w_widx      = (r_state == S_ABS_MUL) ? r_cnt : r_pos[3:2];
    assign w_word      = r_word[w_widx];
    assign w_shift     = w_word >> {r_pos[1:0], 3'b000};
    assign w_byte      = w_shift[7:0];
    assign w_lane      = r_lane[r_cnt];
    assign w_word_step = ({1'b0, r_pos} + 5'd4) <= {1'b0, r_fill};
    assign w_byte_step = r_pos < r_fill;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    if (i_has_byte && (r_fill == 4'd15)) begin
                        n_state = S_ABS_MUL;
                    end else if (i_last_byte) begin
                        n_state = S_FIN_INIT;
                    end
                end
            end
            S_ABS_MUL: n_state = S_ABS_ADD;
            S_ABS_ADD: n_state = S_ABS_ROT;
            S_ABS_ROT: n_state = S_ABS_WB;
            S_ABS_WB: begin
                if (r_cnt != 2'd3) begin
                    n_state = S_ABS_MUL;
                end else if (r_last) begin
                    n_state = S_FIN_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN_INIT: n_state = r_seen ? S_MERGE : S_TAIL_CHK;
            S_MERGE: begin
                if (r_cnt == 2'd3) begin
                    n_state = S_TAIL_CHK;
                end
            end
            S_TAIL_CHK: n_state = (w_word_step || w_byte_step) ? S_TAIL_MUL : S_AVAL_X15;
            S_TAIL_MUL: n_state = S_TAIL_ADD;
            S_TAIL_ADD: n_state = S_TAIL_ROT;
            S_TAIL_ROT: n_state = S_TAIL_WB;
            S_TAIL_WB:  n_state = S_TAIL_CHK;
            S_AVAL_X15: n_state = S_AVAL_M2;
            S_AVAL_M2:  n_state = S_AVAL_X13;
            S_AVAL_X13: n_state = S_AVAL_M3;
            S_AVAL_M3:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and multiplier requests
    always_comb begin
        o_stall       = (r_state != S_IDLE);
        w_in_take     = i_valid && (r_state == S_IDLE);
        w_out_free    = !r_o_valid || !i_stall;
        w_req.en      = 1'b0;
        w_req.operand = r_h;
        w_req.sel     = PR_1;
        case (r_state)
            S_ABS_MUL: begin
                w_req.en      = 1'b1;
                w_req.operand = w_word;
                w_req.sel     = PR_2;
            end
            S_ABS_ROT: begin
                w_req.en      = 1'b1;
                w_req.operand = rotl(r_h, 5'd13);
                w_req.sel     = PR_1;
            end
            S_TAIL_MUL: begin
                w_req.en      = 1'b1;
                w_req.operand = r_wmode ? w_word : {24'd0, w_byte};
                w_req.sel     = r_wmode ? PR_3 : PR_5;
            end
            S_TAIL_ROT: begin
                w_req.en      = 1'b1;
                w_req.operand = r_wmode ? rotl(r_h, 5'd17) : rotl(r_h, 5'd11);
                w_req.sel     = r_wmode ? PR_4 : PR_1;
            end
            S_AVAL_M2: begin
                w_req.en      = 1'b1;
                w_req.sel     = PR_2;
            end
            S_AVAL_M3: begin
                w_req.en      = 1'b1;
                w_req.sel     = PR_3;
            end
            default: begin
                w_req.en      = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= 4'd0;
            r_len     <= 32'd0;
            r_seen    <= 1'b0;
            r_cnt     <= 2'd0;
            r_pos     <= 4'd0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_lane[k] <= lane_init(2'(k));
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take && i_has_byte) begin
                        r_fill <= r_fill + 4'd1;
                        r_len  <= r_len + 32'd1;
                    end
                end
                S_ABS_WB: begin
                    r_lane[r_cnt] <= w_prod;
                    r_cnt         <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_seen <= 1'b1;
                    end
                end
                S_FIN_INIT: r_cnt <= 2'd1;
                S_MERGE:    r_cnt <= r_cnt + 2'd1;
                S_TAIL_WB:  r_pos <= r_pos + (r_wmode ? 4'd4 : 4'd1);
                S_DONE: begin
                    if (w_out_free) begin
                        r_fill    <= 4'd0;
                        r_len     <= 32'd0;
                        r_seen    <= 1'b0;
                        r_cnt     <= 2'd0;
                        r_pos     <= 4'd0;
                        for (int k = 0; k < 4; k++) begin
                            r_lane[k] <= lane_init(2'(k));
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    r_last <= i_last_byte;
                    if (i_has_byte) begin
                        r_word[r_fill[3:2]][{r_fill[1:0], 3'b000} +: 8] <= i_byte_value;
                    end
                end
            end
            S_ABS_ADD:  r_h <= w_lane + w_prod;
            S_FIN_INIT: r_h <= (r_seen ? rotl(w_lane, 5'd1) : PRIME5) + r_len;
            S_MERGE:    r_h <= r_h + rotl(w_lane, lane_rot(r_cnt));
            S_TAIL_CHK: r_wmode <= w_word_step;
            S_TAIL_ADD: r_h <= r_h + w_prod;
            S_TAIL_WB:  r_h <= w_prod;
            S_AVAL_X15: r_h <= r_h ^ (r_h >> 15);
            S_AVAL_X13: r_h <= w_prod ^ (w_prod >> 13);
            S_DONE: begin
                if (w_out_free) begin
                    r_digest <= w_prod ^ (w_prod >> 16);
                end
            end
            default: begin
                r_h <= r_h;
            end
        endcase
    end

    assign o_valid  = r_o_valid;
    assign o_digest = r_digest;

endmodule

>>> design/xxh32_mul.sv
// ----------------------------------------------------------------------------
// xxh32 multiplier
// shared 32 x 32 multiplier by a selected prime, low word registered
// ----------------------------------------------------------------------------
module xxh32_mul (
    input  logic                i_clk,
    input  xxh32_pkg::t_mul_req i_req,
    output logic [31:0]         o_prod
);
    import xxh32_pkg::*;

    logic [31:0] r_prod;
    logic [31:0] n_prod;
    logic [31:0] w_mul;

    assign w_mul  = i_req.operand * prime_value(i_req.sel);
    assign n_prod = i_req.en ? w_mul : r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

>>> design/xxh32_checker.sv
// ----------------------------------------------------------------------------
// xxh32 checker
// port-level assertions for the xxhash32 stream digest, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xxh32_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest
);

    `XXH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "digest dropped")
    `XXH_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_digest), "digest changed while stalled")
    `XXH_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_valid && !o_stall && i_last_byte, o_stall, "no finish after last transfer")
    `XXH_ASSERT_SAME(a_digest_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall) && !o_stall, "digest without finish")

endmodule

bind xxhash32_stream_digest xxh32_checker u_xxh32_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last_byte (i_last_byte),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_digest    (o_digest)
);
